// ===== sv/rtppk_pkg.sv =====
package rtppk_pkg;

  localparam int unsigned HdrLen = 12;
  localparam int unsigned HdrIdxW = 4;
  localparam int unsigned AddrW = 4;

  localparam logic [12:0] MuMax = 13'h1FFF;
  localparam logic [16:0] MuBias = 17'd33;
  localparam logic [3:0] MantMask = 4'h0f;
  localparam logic [7:0] RtpVersionByte = 8'h80;
  localparam logic [7:0] RtpTypeByte = 8'h00;

  typedef enum logic [1:0] {
    RegSessionEnable,
    RegStreamSourceId,
    RegInitialSequence,
    RegInitialTimestamp
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] audio_sample;
    logic               end_of_packet;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       is_header;
    logic       last_byte;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  payload;
    logic        eop;
    logic        need_hdr;
    logic [15:0] seq;
    logic [31:0] ts;
  } cmd_t;

  typedef struct packed {
    logic        seq_we;
    logic        ts_we;
    logic [31:0] wdata;
  } cnt_load_t;

  function automatic logic [7:0] mulaw_encode(logic signed [15:0] s);
    logic        neg;
    logic [16:0] mag;
    logic [16:0] biased;
    logic [12:0] sat;
    logic [2:0]  ex;
    logic [3:0]  man;
    neg = s[15];
    mag = neg ? (17'd0 - {s[15], s}) : {1'b0, s};
    biased = mag + MuBias;
    sat = (biased > {4'd0, MuMax}) ? MuMax : biased[12:0];
    ex = 3'd0;
    man = sat[4:1] & MantMask;
    for (int i = 5; i <= 12; i++) begin
      if (sat[i]) begin
        ex = 3'(i - 5);
        man = sat[i-1 -: 4] & MantMask;
      end
    end
    return ~{neg, ex, man};
  endfunction

endpackage

// ===== sv/rtppk_front.sv =====
module rtppk_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 enable_i,
  input  rtppk_pkg::in_beat_t  in_data_i,
  input  rtppk_pkg::cnt_load_t load_i,
  output logic                 cmd_we_o,
  output rtppk_pkg::cmd_t      cmd_o,
  output logic [15:0]          seq_o,
  output logic [31:0]          ts_o
);

  logic [15:0] seq_q, seq_d;
  logic [31:0] ts_q, ts_d;
  logic        inside_q, inside_d;
  logic        active;

  assign active = accept_i && enable_i;

  always_comb begin
    seq_d = seq_q;
    ts_d = ts_q;
    inside_d = inside_q;
    if (active) begin
      ts_d = ts_q + 32'd1;
      if (in_data_i.end_of_packet) begin
        seq_d = seq_q + 16'd1;
        inside_d = 1'b0;
      end else begin
        inside_d = 1'b1;
      end
    end
    if (load_i.seq_we) begin
      seq_d = load_i.wdata[15:0];
    end
    if (load_i.ts_we) begin
      ts_d = load_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
      ts_q <= '0;
      inside_q <= 1'b0;
    end else begin
      seq_q <= seq_d;
      ts_q <= ts_d;
      inside_q <= inside_d;
    end
  end

  always_comb begin
    cmd_o.payload = rtppk_pkg::mulaw_encode(in_data_i.audio_sample);
    cmd_o.eop = in_data_i.end_of_packet;
    cmd_o.need_hdr = !inside_q;
    cmd_o.seq = seq_q;
    cmd_o.ts = ts_q;
  end

  assign cmd_we_o = active;
  assign seq_o = seq_q;
  assign ts_o = ts_q;

endmodule

// ===== sv/rtppk_queue.sv =====
module rtppk_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  rtppk_pkg::cmd_t wdata_i,
  input  logic            pop_i,
  output rtppk_pkg::cmd_t head_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rtppk_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (we_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (we_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!we_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign head_o = mem_q[rd_ptr_q];
  assign full_o = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

endmodule

// ===== sv/rtppk_back.sv =====
module rtppk_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rtppk_pkg::cmd_t      head_i,
  input  logic                 q_empty_i,
  output logic                 q_pop_o,
  input  logic [31:0]          ssrc_i,
  input  logic                 pop_i,
  output logic                 empty_o,
  output rtppk_pkg::out_beat_t out_data_o
);

  logic [rtppk_pkg::HdrIdxW-1:0] idx_q, idx_d;
  logic                          out_valid_q, out_valid_d;
  rtppk_pkg::out_beat_t          out_q, out_d;
  logic                          take;
  logic                          in_hdr;
  logic [7:0]                    hdr_byte;

  assign take = !q_empty_i && (!out_valid_q || pop_i);
  assign in_hdr = head_i.need_hdr && (idx_q != rtppk_pkg::HdrIdxW'(rtppk_pkg::HdrLen));

  always_comb begin
    unique case (idx_q)
      4'd0:    hdr_byte = rtppk_pkg::RtpVersionByte;
      4'd1:    hdr_byte = rtppk_pkg::RtpTypeByte;
      4'd2:    hdr_byte = head_i.seq[15:8];
      4'd3:    hdr_byte = head_i.seq[7:0];
      4'd4:    hdr_byte = head_i.ts[31:24];
      4'd5:    hdr_byte = head_i.ts[23:16];
      4'd6:    hdr_byte = head_i.ts[15:8];
      4'd7:    hdr_byte = head_i.ts[7:0];
      4'd8:    hdr_byte = ssrc_i[31:24];
      4'd9:    hdr_byte = ssrc_i[23:16];
      4'd10:   hdr_byte = ssrc_i[15:8];
      4'd11:   hdr_byte = ssrc_i[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !pop_i;
    q_pop_o = 1'b0;
    if (take) begin
      out_valid_d = 1'b1;
      if (in_hdr) begin
        out_d.packet_byte = hdr_byte;
        out_d.is_header = 1'b1;
        out_d.last_byte = 1'b0;
        idx_d = idx_q + 1'b1;
      end else begin
        out_d.packet_byte = head_i.payload;
        out_d.is_header = 1'b0;
        out_d.last_byte = head_i.eop;
        idx_d = '0;
        q_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o = !out_valid_q;
  assign out_data_o = out_q;

endmodule

// ===== sv/rtp_pcmu_packetizer.sv =====
// The first beat caused by a sample is registered in the command queue and then in the output register.
// Throughput: one output beat per cycle while the receiver pops, from the header/payload
// sequencer; a sample that opens a packet costs 13 beats, others 1, and a small command queue
// absorbs sample bursts. Input acceptance is one sample per cycle while the queue has room.
// Reset is asynchronous and active low; it clears control state and configuration registers,
// not output data or queue storage; the block accepts samples and register writes once it ends.
module rtp_pcmu_packetizer #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  rtppk_pkg::in_beat_t                 in_data_i,
  input  logic                                pop,
  output logic                                empty,
  output rtppk_pkg::out_beat_t                out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rtppk_pkg::AddrW-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic                 sess_en_q;
  logic [31:0]          ssrc_q;
  logic                 cfg_we;
  rtppk_pkg::reg_idx_e  reg_idx;
  rtppk_pkg::cnt_load_t load;
  logic                 accept;
  logic                 cmd_we;
  rtppk_pkg::cmd_t      cmd;
  rtppk_pkg::cmd_t      head;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  logic [15:0]          seq;
  logic [31:0]          ts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign reg_idx = rtppk_pkg::reg_idx_e'(paddr[rtppk_pkg::AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_en_q <= 1'b0;
      ssrc_q <= '0;
    end else if (cfg_we) begin
      if (reg_idx == rtppk_pkg::RegSessionEnable) begin
        sess_en_q <= pwdata[0];
      end
      if (reg_idx == rtppk_pkg::RegStreamSourceId) begin
        ssrc_q <= pwdata;
      end
    end
  end

  always_comb begin
    load.seq_we = cfg_we && (reg_idx == rtppk_pkg::RegInitialSequence);
    load.ts_we = cfg_we && (reg_idx == rtppk_pkg::RegInitialTimestamp);
    load.wdata = pwdata;
  end

  always_comb begin
    unique case (reg_idx)
      rtppk_pkg::RegSessionEnable:    prdata = {31'd0, sess_en_q};
      rtppk_pkg::RegStreamSourceId:   prdata = ssrc_q;
      rtppk_pkg::RegInitialSequence:  prdata = {16'd0, seq};
      rtppk_pkg::RegInitialTimestamp: prdata = ts;
      default:                        prdata = '0;
    endcase
  end

  assign full = q_full;
  assign accept = push && !full;

  rtppk_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .enable_i  (sess_en_q),
    .in_data_i (in_data_i),
    .load_i    (load),
    .cmd_we_o  (cmd_we),
    .cmd_o     (cmd),
    .seq_o     (seq),
    .ts_o      (ts)
  );

  rtppk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cmd_we),
    .wdata_i (cmd),
    .pop_i   (q_pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rtppk_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .ssrc_i     (ssrc_q),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_data_o (out_data_o)
  );

  a_no_write_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_we |-> !q_full)
    else $error("Command written into a full queue.");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("Command taken from an empty queue.");

  a_seq_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load.seq_we |=> (seq == $past(pwdata[15:0])))
    else $error("Sequence counter did not take the written value.");

  a_no_beat_when_disabled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !sess_en_q) |-> !cmd_we)
    else $error("Sample queued while the session is disabled.");

endmodule

// ===== test/rtp_pcmu_packetizer_tb.sv =====
module rtp_pcmu_packetizer_tb;
  import rtppk_pkg::*;

  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned MaxPrinted = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  in_beat_t            in_data_i = '0;
  logic                pop = 1'b0;
  logic                empty;
  out_beat_t           out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  rtp_pcmu_packetizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .pop        (pop),
    .empty      (empty),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // Session state as the packetizer should hold it.
  logic        sess_on = 1'b0;
  logic [31:0] ssrc_val = '0;
  logic [15:0] seq_no = '0;
  logic [31:0] run_ts = '0;
  logic        pkt_open = 1'b0;

  out_beat_t   pending_bytes[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned errors = 0;
  int unsigned samples_taken = 0;
  int unsigned samples_dropped = 0;
  int unsigned packets_closed = 0;
  int unsigned beats_checked = 0;
  int unsigned input_stalls = 0;

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  function automatic logic [7:0] mulaw_of(input logic signed [15:0] smp);
    logic [16:0] mag;
    logic [12:0] clip;
    logic [3:0]  mant;
    int          lead;
    mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
    mag = mag + 17'd33;
    clip = (mag > 17'h1FFF) ? 13'h1FFF : mag[12:0];
    lead = 12;
    while (lead > 5 && !clip[lead]) lead--;
    mant = clip[lead-1 -: 4];
    return ~{smp[15], 3'(lead - 5), mant};
  endfunction

  task automatic encode_sample(input in_beat_t b);
    logic [95:0] hdr;
    if (!sess_on) begin
      samples_dropped++;
      return;
    end
    samples_taken++;
    if (!pkt_open) begin
      hdr = {RtpVersionByte, RtpTypeByte, seq_no, run_ts, ssrc_val};
      for (int k = 0; k < HdrLen; k++) begin
        pending_bytes.push_back(out_beat_t'{packet_byte: hdr[95-8*k -: 8],
                                            is_header: 1'b1, last_byte: 1'b0});
      end
      pkt_open = 1'b1;
    end
    pending_bytes.push_back(out_beat_t'{packet_byte: mulaw_of(b.audio_sample),
                                        is_header: 1'b0, last_byte: b.end_of_packet});
    run_ts = run_ts + 32'd1;
    if (b.end_of_packet) begin
      seq_no = seq_no + 16'd1;
      pkt_open = 1'b0;
      packets_closed++;
    end
  endtask

  task automatic send_sample(input logic signed [15:0] smp, input logic eop);
    in_beat_t b;
    b.audio_sample = smp;
    b.end_of_packet = eop;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      in_data_i <= in_beat_t'($urandom);
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (full) begin
      input_stalls++;
      @(posedge clk_i);
    end
    encode_sample(b);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    push <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegSessionEnable:    sess_on = val[0];
      RegStreamSourceId:   ssrc_val = val;
      RegInitialSequence:  seq_no = val[15:0];
      RegInitialTimestamp: run_ts = val;
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every expected beat has come out, then lets the pipeline settle.
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(256)) - 128);
      2: begin
        case ($urandom_range(3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      default: return 16'($signed($urandom_range(16383)) - 8192);
    endcase
  endfunction

  task automatic test_header_and_extremes();
    logic signed [15:0] pcm[14];
    pcm = '{-16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'sd30, 16'sd31, 16'sd32, 16'sd95,
            16'sd96, 16'sd8158, 16'sd8159, -16'sd8159, -16'sd8160, -16'sd32767};
    write_reg(RegStreamSourceId, 32'h8123_45FE);
    write_reg(RegInitialSequence, 32'h0000_FFFE);
    write_reg(RegInitialTimestamp, 32'hFFFF_FFFE);
    write_reg(RegSessionEnable, 32'd1);
    send_sample(16'sh7FFF, 1'b1);
    foreach (pcm[k]) send_sample(pcm[k], k == 13);
    drain();
  endtask

  task automatic test_session_gate();
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd1000, 1'b0);
    drain();
    write_reg(RegSessionEnable, 32'd0);
    send_sample(16'sd4000, 1'b0);
    send_sample(-16'sd4000, 1'b1);
    drain();
    write_reg(RegSessionEnable, 32'd1);
    send_sample(16'sd12345, 1'b1);
    drain();
  endtask

  task automatic test_counter_load();
    send_sample(-16'sd2, 1'b0);
    drain();
    write_reg(RegInitialSequence, 32'h0000_0000);
    write_reg(RegInitialTimestamp, 32'h0000_0000);
    write_reg(RegStreamSourceId, 32'h0000_0000);
    send_sample(16'sd500, 1'b1);
    send_sample(-16'sd500, 1'b1);
    drain();
    write_reg(RegStreamSourceId, 32'hFFFF_FFFF);
    write_reg(RegInitialTimestamp, 32'hFFFF_FFFF);
    write_reg(RegInitialSequence, 32'hFFFF_FFFF);
    send_sample(16'sd7, 1'b1);
    drain();
  endtask

  // The receiver holds off while a long packet streams in, so the block fills and stalls.
  task automatic test_backpressure();
    hold_reqs++;
    for (int k = 0; k < 20; k++) send_sample(pick_sample(), k == 19);
    drain();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned gap;
    drain();
    write_reg(RegStreamSourceId, ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom);
    write_reg(RegInitialSequence, $urandom);
    write_reg(RegInitialTimestamp, ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 : $urandom);
    write_reg(RegSessionEnable, 32'd1);
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(19) == 0) begin
        drain();
        write_reg(RegSessionEnable, {31'($urandom), 1'b0});
        gap = $urandom_range(1, 3);
        repeat (gap) send_sample(pick_sample(), 1'($urandom));
        drain();
        write_reg(RegSessionEnable, 32'd1);
      end
      send_sample(pick_sample(), $urandom_range(3) == 0);
      sent++;
    end
    drain();
  endtask

  always @(negedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && pop && !empty) begin
      beats_checked++;
      if (pending_bytes.size() == 0) begin
        flag_error($sformatf("unexpected beat, byte %02h", out_data_o.packet_byte));
      end else begin
        want = pending_bytes.pop_front();
        if (out_data_o.packet_byte !== want.packet_byte) begin
          flag_error($sformatf("packet_byte %02h, expected %02h",
                               out_data_o.packet_byte, want.packet_byte));
        end
        if (out_data_o.is_header !== want.is_header) begin
          flag_error($sformatf("is_header %b, expected %b",
                               out_data_o.is_header, want.is_header));
        end
        if (out_data_o.last_byte !== want.last_byte) begin
          flag_error($sformatf("last_byte %b, expected %b",
                               out_data_o.last_byte, want.last_byte));
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog expired with %0d beats outstanding.", pending_bytes.size());
    $display("rtp_pcmu_packetizer_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 25;
    rx_idle_pct = 81;
    test_header_and_extremes();
    test_session_gate();
    test_counter_load();
    test_random_traffic(20);

    tx_idle_pct = 81;
    rx_idle_pct = 25;
    test_random_traffic(20);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random_traffic(20);

    drain();
    if (pending_bytes.size() != 0) begin
      flag_error($sformatf("%0d expected beats never arrived", pending_bytes.size()));
    end
    $display("Sent %0d samples into %0d closed packets, %0d dropped while disabled.",
             samples_taken, packets_closed, samples_dropped);
    $display("Checked %0d output beats; input was held off for %0d cycles.",
             beats_checked, input_stalls);
    if (errors == 0) begin
      $display("rtp_pcmu_packetizer_tb: done, clean");
    end else begin
      $display("rtp_pcmu_packetizer_tb: done, errors");
    end
    $finish;
  end

endmodule
